// ===== rtl/pan_servo_target_tracker_core_assert.svh =====
// Assertion macros shared by the pan servo target tracker RTL.
`ifndef PAN_SERVO_TARGET_TRACKER_CORE_ASSERT_SVH
`define PAN_SERVO_TARGET_TRACKER_CORE_ASSERT_SVH

// same-cycle implication
`define PST_ASSERT_IMPL(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PST_ASSERT_NEXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pst_pkg.sv =====
// Types and constants of the pan servo target tracker.
`default_nettype none

package pst_pkg;

    localparam int POS_BITS    = 10;
    localparam int CFG_W       = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int VAL_W       = 12;
    localparam int STEP_W      = 13;
    localparam int SIZE_W      = 4;
    localparam int SIDE_W      = 2;
    localparam int ANGLE_OUT_W = 16;
    localparam int FULL_DEG    = 180;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_EDGE   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_EDGE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SMALL_STEP  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BIG_STEP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_LOW   = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PULSE_HIGH  = 3'd6;

    localparam logic [SIDE_W-1:0] SIDE_NONE   = 2'd0;
    localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd1;
    localparam logic [SIDE_W-1:0] SIDE_CENTRE = 2'd2;
    localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd3;

    localparam logic [POS_BITS-1:0] FRAME_WIDTH_RST = 10'd400;
    localparam logic [POS_BITS-1:0] LEFT_EDGE_RST   = 10'd163;
    localparam logic [POS_BITS-1:0] RIGHT_EDGE_RST  = 10'd236;
    localparam logic [VAL_W-1:0]    SMALL_STEP_RST  = 12'd896;
    localparam logic [VAL_W-1:0]    BIG_STEP_RST    = 12'd1408;
    localparam logic [VAL_W-1:0]    PULSE_LOW_RST   = 12'd500;
    localparam logic [VAL_W-1:0]    PULSE_HIGH_RST  = 12'd2600;
    localparam logic [STEP_W-1:0]   STEP_RST        = 13'd896;
    localparam logic [STEP_W-1:0]   STEP_MAX        = 13'd8191;
    localparam logic [SIZE_W-1:0]   SIZE_MIN        = 4'd1;
    localparam logic [SIZE_W-1:0]   SIZE_MAX        = 4'd4;

    typedef struct packed {
        logic                opponent_seen;
        logic [POS_BITS-1:0] opponent_x;
        logic [SIZE_W-1:0]   opponent_size;
    } pst_in_t;

    typedef struct packed {
        logic [VAL_W-1:0]       pulse_width_us;
        logic [ANGLE_OUT_W-1:0] pan_angle;
        logic [SIDE_W-1:0]      last_side;
    } pst_out_t;

    typedef struct packed {
        logic start;
        logic divide;
        logic quick;
    } pst_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } pst_sts_t;

endpackage

`default_nettype wire

// ===== rtl/pan_servo_target_tracker_core.sv =====
// Pan servo target tracker: angle, step and side state with servo pulse output.
//
// Input channel s_valid/s_ready/s_data carries one control tick: seen flag,
// horizontal position and size class of the opponent. Output channel
// m_valid/m_ready/m_data returns one transaction per tick: pulse width in
// microseconds, clamped pan angle and the remembered side.
// Configuration is written via cfg_wr_en/cfg_wr_index/cfg_wr_data by the user
// only while no tick is in flight, which the block does not enforce; a write
// takes effect at once, with no wait state. Each tick makes four passes
// through one bit-serial multiply/divide unit: step multiply, step divide,
// pulse multiply and pulse divide by full scale.
// s_ready is high only between ticks. A result held by a stalled receiver
// sits in the output register while the next tick is accepted and worked;
// that tick then waits for the register to empty before it is delivered.
// Synchronous reset (aresetn low) restores the default configuration, an
// angle of 90 degrees, the centre step and no remembered side.
`default_nettype none
`include "pan_servo_target_tracker_core_assert.svh"

module pan_servo_target_tracker_core #(
    parameter int ANGLE_FRAC_BITS = 8
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  pst_pkg::pst_in_t                 s_data,
    output logic                             m_valid,
    input  logic                             m_ready,
    output pst_pkg::pst_out_t                m_data,
    input  logic                             cfg_wr_en,
    input  logic [pst_pkg::CFG_IDX_W-1:0]    cfg_wr_index,
    input  logic [pst_pkg::CFG_W-1:0]        cfg_wr_data
);
    import pst_pkg::*;

    localparam int AW = 8 + ANGLE_FRAC_BITS;
    localparam int NW = VAL_W;
    localparam int PW = AW + NW;
    localparam int EW = ((AW > STEP_W) ? AW : STEP_W) + 2;
    localparam logic [AW-1:0] FULL_SCALE = AW'(FULL_DEG << ANGLE_FRAC_BITS);
    localparam logic [AW-1:0] HALF_SCALE = AW'((FULL_DEG / 2) << ANGLE_FRAC_BITS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_MUL1  = 3'd1;
    localparam logic [2:0] S_DIV1  = 3'd2;
    localparam logic [2:0] S_ANGLE = 3'd3;
    localparam logic [2:0] S_PULSE = 3'd4;
    localparam logic [2:0] S_MUL2  = 3'd5;
    localparam logic [2:0] S_DIV2  = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    localparam logic [1:0] M_INTERP = 2'd0;
    localparam logic [1:0] M_BIG    = 2'd1;
    localparam logic [1:0] M_SMALL  = 2'd2;
    localparam logic [1:0] M_KEEP   = 2'd3;

    localparam logic [1:0] DIR_HOLD = 2'd0;
    localparam logic [1:0] DIR_DOWN = 2'd1;
    localparam logic [1:0] DIR_UP   = 2'd2;

    logic [POS_BITS-1:0] frame_width_reg, left_edge_reg, right_edge_reg;
    logic [VAL_W-1:0]    small_step_reg, big_step_reg, pulse_low_reg, pulse_high_reg;

    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       angle_reg, angle_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [SIDE_W-1:0]   side_reg, side_next;
    logic [1:0]          mode_reg, mode_next;
    logic [1:0]          dir_reg, dir_next;
    logic [POS_BITS-1:0] den_reg, den_next;
    logic                m_valid_reg, m_valid_next;
    pst_out_t            m_data_reg, m_data_next;

    logic                accept;
    logic [POS_BITS-1:0] x, half, pos_dist, den;
    logic                lt_h, in_frame, sized;
    logic                step_neg, pulse_neg;
    logic [VAL_W-1:0]    dmag, pmag;

    logic [PW-1:0]       q;
    logic [STEP_W:0]     sum_pos;
    logic [STEP_W-1:0]   pos_val, neg_val, interp;
    logic                neg_floor;

    logic signed [EW-1:0] a_ext, s_ext, fs_ext, a_sum;
    logic [AW-1:0]        angle_clamp;
    logic [VAL_W-1:0]     pulse;

    pst_ctl_t            md_ctl;
    pst_sts_t            md_sts;
    logic [AW-1:0]       md_opa;
    logic [NW-1:0]       md_opb;
    logic [PW-1:0]       md_result;
    logic [AW-1:0]       md_rem;

    assign s_ready = (state_reg == S_IDLE);
    assign accept  = s_valid && s_ready;

    assign x        = s_data.opponent_x;
    assign half     = {1'b0, frame_width_reg[POS_BITS-1:1]};
    assign lt_h     = x < half;
    assign in_frame = x <= frame_width_reg;
    assign pos_dist = lt_h ? (half - x) : (x - half);
    assign den      = lt_h ? (half - POS_BITS'(1)) : (frame_width_reg - half);
    assign sized    = (s_data.opponent_size >= SIZE_MIN) && (s_data.opponent_size <= SIZE_MAX);

    assign step_neg  = big_step_reg < small_step_reg;
    assign dmag      = step_neg ? (small_step_reg - big_step_reg)
                                : (big_step_reg - small_step_reg);
    assign pulse_neg = pulse_high_reg < pulse_low_reg;
    assign pmag      = pulse_neg ? (pulse_low_reg - pulse_high_reg)
                                 : (pulse_high_reg - pulse_low_reg);

    // interpolated step, saturated to the step register range
    assign q         = md_result;
    assign sum_pos   = {2'b00, small_step_reg} + {1'b0, q[STEP_W-1:0]};
    assign pos_val   = ((|q[PW-1:STEP_W]) || sum_pos[STEP_W]) ? STEP_MAX
                                                              : sum_pos[STEP_W-1:0];
    assign neg_floor = (|q[PW-1:VAL_W]) || (q[VAL_W-1:0] >= small_step_reg);
    assign neg_val   = neg_floor ? '0 : {1'b0, small_step_reg - q[VAL_W-1:0]};
    assign interp    = step_neg ? neg_val : pos_val;

    assign a_ext  = signed'({{(EW-AW){1'b0}}, angle_reg});
    assign s_ext  = signed'({{(EW-STEP_W){1'b0}}, step_reg});
    assign fs_ext = signed'({{(EW-AW){1'b0}}, FULL_SCALE});

    always_comb begin
        case (dir_reg)
            DIR_DOWN: a_sum = a_ext - s_ext;
            DIR_UP:   a_sum = a_ext + s_ext;
            default:  a_sum = a_ext;
        endcase
        if (a_sum[EW-1]) begin
            angle_clamp = '0;
        end else if (a_sum > fs_ext) begin
            angle_clamp = FULL_SCALE;
        end else begin
            angle_clamp = a_sum[AW-1:0];
        end
    end

    assign pulse = pulse_neg
                 ? (pulse_low_reg - md_result[VAL_W-1:0] - {{(VAL_W-1){1'b0}}, |md_rem})
                 : (pulse_low_reg + md_result[VAL_W-1:0]);

    always_comb begin
        state_next   = state_reg;
        angle_next   = angle_reg;
        step_next    = step_reg;
        side_next    = side_reg;
        mode_next    = mode_reg;
        dir_next     = dir_reg;
        den_next     = den_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        md_ctl       = '{start: 1'b0, divide: 1'b0, quick: 1'b0};
        md_opa       = {{(AW-POS_BITS){1'b0}}, pos_dist};
        md_opb       = dmag;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE: begin
                if (accept) begin
                    md_ctl     = '{start: 1'b1, divide: 1'b0, quick: 1'b0};
                    den_next   = den;
                    state_next = S_MUL1;
                    if (!s_data.opponent_seen) begin
                        mode_next = M_BIG;
                        dir_next  = (side_reg == SIDE_LEFT) ? DIR_DOWN : DIR_UP;
                    end else begin
                        if (lt_h) begin
                            mode_next = (den == '0) ? M_BIG : M_INTERP;
                        end else if (in_frame) begin
                            mode_next = (den == '0) ? M_SMALL : M_INTERP;
                        end else begin
                            mode_next = M_KEEP;
                        end
                        if (x < left_edge_reg) begin
                            side_next = SIDE_LEFT;
                            dir_next  = sized ? DIR_DOWN : DIR_HOLD;
                        end else if (x < right_edge_reg) begin
                            side_next = SIDE_CENTRE;
                            dir_next  = DIR_HOLD;
                        end else begin
                            side_next = SIDE_RIGHT;
                            dir_next  = sized ? DIR_UP : DIR_HOLD;
                        end
                    end
                end
            end
            S_MUL1: begin
                md_opa = {{(AW-POS_BITS){1'b0}}, den_reg};
                if (md_sts.done) begin
                    md_ctl     = '{start: 1'b1, divide: 1'b1, quick: 1'b0};
                    state_next = S_DIV1;
                end
            end
            S_DIV1: begin
                if (md_sts.done) begin
                    case (mode_reg)
                        M_BIG:    step_next = {1'b0, big_step_reg};
                        M_SMALL:  step_next = {1'b0, small_step_reg};
                        M_INTERP: step_next = interp;
                        default:  step_next = step_reg;
                    endcase
                    state_next = S_ANGLE;
                end
            end
            S_ANGLE: begin
                angle_next = angle_clamp;
                state_next = S_PULSE;
            end
            S_PULSE: begin
                md_opa     = FULL_SCALE - angle_reg;
                md_opb     = pmag;
                md_ctl     = '{start: 1'b1, divide: 1'b0, quick: 1'b0};
                state_next = S_MUL2;
            end
            S_MUL2: begin
                md_opa = FULL_SCALE;
                if (md_sts.done) begin
                    md_ctl     = '{start: 1'b1, divide: 1'b1, quick: 1'b1};
                    state_next = S_DIV2;
                end
            end
            S_DIV2: begin
                if (md_sts.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{pulse_width_us: pulse,
                                     pan_angle:      ANGLE_OUT_W'(angle_reg),
                                     last_side:      side_reg};
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    pst_muldiv #(
        .AW (AW),
        .NW (NW)
    ) u_muldiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (md_ctl),
        .opa       (md_opa),
        .opb       (md_opb),
        .dividend  (md_result),
        .result    (md_result),
        .remainder (md_rem),
        .sts       (md_sts)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg <= FRAME_WIDTH_RST;
            left_edge_reg   <= LEFT_EDGE_RST;
            right_edge_reg  <= RIGHT_EDGE_RST;
            small_step_reg  <= SMALL_STEP_RST;
            big_step_reg    <= BIG_STEP_RST;
            pulse_low_reg   <= PULSE_LOW_RST;
            pulse_high_reg  <= PULSE_HIGH_RST;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                CFG_FRAME_WIDTH: frame_width_reg <= cfg_wr_data[POS_BITS-1:0];
                CFG_LEFT_EDGE:   left_edge_reg   <= cfg_wr_data[POS_BITS-1:0];
                CFG_RIGHT_EDGE:  right_edge_reg  <= cfg_wr_data[POS_BITS-1:0];
                CFG_SMALL_STEP:  small_step_reg  <= cfg_wr_data[VAL_W-1:0];
                CFG_BIG_STEP:    big_step_reg    <= cfg_wr_data[VAL_W-1:0];
                CFG_PULSE_LOW:   pulse_low_reg   <= cfg_wr_data[VAL_W-1:0];
                CFG_PULSE_HIGH:  pulse_high_reg  <= cfg_wr_data[VAL_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            angle_reg   <= HALF_SCALE;
            step_reg    <= STEP_RST;
            side_reg    <= SIDE_NONE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            angle_reg   <= angle_next;
            step_reg    <= step_next;
            side_reg    <= side_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        dir_reg    <= dir_next;
        den_reg    <= den_next;
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    `PST_ASSERT_NEXT(a_accept_starts_mul, aclk, aresetn, s_valid && s_ready, state_reg == S_MUL1 && md_sts.busy, "accepted transaction did not start the multiply")
    `PST_ASSERT_IMPL(a_done_in_wait, aclk, aresetn, md_sts.done, state_reg == S_MUL1 || state_reg == S_DIV1 || state_reg == S_MUL2 || state_reg == S_DIV2, "serial unit finished outside a wait state")
    `PST_ASSERT_NEXT(a_out_from_out_state, aclk, aresetn, !m_valid && state_reg != S_OUT, !m_valid, "result raised outside the output state")
    `PST_ASSERT_NEXT(a_angle_in_range, aclk, aresetn, state_reg == S_ANGLE, angle_reg <= FULL_SCALE, "pan angle beyond full scale")

endmodule

`default_nettype wire

// ===== rtl/pst_muldiv.sv =====
// Bit-serial shift-add multiplier and restoring divider, one bit per cycle.
`default_nettype none

module pst_muldiv #(
    parameter int AW = 16,
    parameter int NW = 12
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  pst_pkg::pst_ctl_t  ctl,
    input  logic [AW-1:0]      opa,
    input  logic [NW-1:0]      opb,
    input  logic [AW+NW-1:0]   dividend,
    output logic [AW+NW-1:0]   result,
    output logic [AW-1:0]      remainder,
    output pst_pkg::pst_sts_t  sts
);
    import pst_pkg::*;

    localparam int PW = AW + NW;
    localparam int CW = $clog2(PW + 1);

    logic [PW-1:0] acc_reg, acc_next;
    logic [PW-1:0] mcand_reg, mcand_next;
    logic [NW-1:0] mplr_reg, mplr_next;
    logic [AW-1:0] rem_reg, rem_next;
    logic [AW-1:0] dvsr_reg, dvsr_next;
    logic          div_reg, div_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [AW+1:0] trial;

    assign trial = {1'b0, rem_reg, acc_reg[PW-1]} - {2'b00, dvsr_reg};

    always_comb begin
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        mplr_next  = mplr_reg;
        rem_next   = rem_reg;
        dvsr_next  = dvsr_reg;
        div_next   = div_reg;
        busy_next  = busy_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        if (ctl.start) begin
            busy_next  = 1'b1;
            div_next   = ctl.divide;
            dvsr_next  = opa;
            mcand_next = {{NW{1'b0}}, opa};
            mplr_next  = opb;
            if (!ctl.divide) begin
                acc_next = '0;
                rem_next = '0;
                cnt_next = CW'(NW);
            end else if (ctl.quick) begin
                rem_next = dividend[PW-1:NW];
                acc_next = {dividend[NW-1:0], {AW{1'b0}}};
                cnt_next = CW'(NW);
            end else begin
                rem_next = '0;
                acc_next = dividend;
                cnt_next = CW'(PW);
            end
        end else if (busy_reg) begin
            if (div_reg) begin
                if (!trial[AW+1]) begin
                    rem_next = trial[AW-1:0];
                    acc_next = {acc_reg[PW-2:0], 1'b1};
                end else begin
                    rem_next = {rem_reg[AW-2:0], acc_reg[PW-1]};
                    acc_next = {acc_reg[PW-2:0], 1'b0};
                end
            end else begin
                if (mplr_reg[0]) begin
                    acc_next = acc_reg + mcand_reg;
                end
                mcand_next = {mcand_reg[PW-2:0], 1'b0};
                mplr_next  = {1'b0, mplr_reg[NW-1:1]};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        mplr_reg  <= mplr_next;
        rem_reg   <= rem_next;
        dvsr_reg  <= dvsr_next;
        div_reg   <= div_next;
    end

    assign result    = acc_reg;
    assign remainder = rem_reg;
    assign sts       = '{busy: busy_reg, done: done_reg};

endmodule

`default_nettype wire
